// ===== src/rab_pkg.sv =====
// Shared types, constants and helpers for the RGBA alpha blend unit.
package rab_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned WGT_W  = 9;
    localparam int unsigned FAC_W  = 16;
    localparam int unsigned MUL_W  = 16;
    localparam int unsigned SUM_W  = 24;

    localparam logic [WGT_W-1:0] WEIGHT_ONE  = 9'd256;
    localparam logic [FAC_W-1:0] OVERLAY_DIV = 16'd65280;

    localparam logic REG_OVERLAY_MODE = 1'b0;
    localparam logic REG_BLEND_WEIGHT = 1'b1;

    typedef struct packed {
        logic             overlay_mode;
        logic [WGT_W-1:0] blend_weight;
    } t_cfg;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    // floor(x / 255), exact for x below 65280
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ===== src/rab_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
module rab_cfg_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output rab_pkg::t_cfg o_cfg
);
    import rab_pkg::*;

    logic             r_overlay_mode;
    logic [WGT_W-1:0] r_blend_weight;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlay_mode <= 1'b0;
            r_blend_weight <= 9'd128;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_OVERLAY_MODE: r_overlay_mode <= pwdata[0];
                REG_BLEND_WEIGHT: r_blend_weight <= pwdata[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_OVERLAY_MODE: prdata = {31'd0, r_overlay_mode};
            REG_BLEND_WEIGHT: prdata = {23'd0, r_blend_weight};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg.overlay_mode = r_overlay_mode;
    assign o_cfg.blend_weight = r_blend_weight;

endmodule

// ===== src/rab_pipe_ctrl.sv =====
// Valid bits and per-stage advance enables of the four-stage pipeline.
module rab_pipe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rab_pkg::t_pipe_en o_en
);
    import rab_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4;

    always_comb begin
        o_en.s4 = ~r_v4 | i_out_ready;
        o_en.s3 = ~r_v3 | o_en.s4;
        o_en.s2 = ~r_v2 | o_en.s3;
        o_en.s1 = ~r_v1 | o_en.s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (o_en.s1) r_v1 <= i_in_valid;
            if (o_en.s2) r_v2 <= r_v1;
            if (o_en.s3) r_v3 <= r_v2;
            if (o_en.s4) r_v4 <= r_v3;
        end
    end

    assign o_in_ready  = o_en.s1;
    assign o_out_valid = r_v4;

`ifndef SYNTH
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_en.s1 |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input stalled with an empty stage");
    a_accept_v1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v1)
        else $error("accepted item missing in stage one");
    a_advance_v2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && o_en.s2) |=> r_v2)
        else $error("item lost between stage one and two");
    a_advance_v4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && o_en.s4) |=> r_v4)
        else $error("item lost between stage three and output");
`endif

endmodule

// ===== src/rab_factor_stage.sv =====
// Stage one weight factors shared by all color lanes.
module rab_factor_stage (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  rab_pkg::t_cfg                i_cfg,
    input  logic [rab_pkg::CHAN_W-1:0]   i_second_alpha,
    output logic [rab_pkg::FAC_W-1:0]    o_f1,
    output logic [rab_pkg::FAC_W-1:0]    o_f2,
    output logic                         o_blend
);
    import rab_pkg::*;

    logic [WGT_W-1:0] w_eff;
    logic [16:0]      k_full;
    logic [FAC_W-1:0] k;
    logic [FAC_W-1:0] n_f1, n_f2;
    logic [FAC_W-1:0] r_f1, r_f2;
    logic             r_blend;

    always_comb begin
        w_eff  = i_cfg.blend_weight[WGT_W-1] ? WEIGHT_ONE : i_cfg.blend_weight;
        k_full = 17'(i_second_alpha) * 17'(w_eff);
        k      = k_full[FAC_W-1:0];
        if (i_cfg.overlay_mode) begin
            n_f1 = OVERLAY_DIV - k;
            n_f2 = k;
        end else begin
            n_f1 = FAC_W'(WEIGHT_ONE - w_eff);
            n_f2 = FAC_W'(w_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1    <= n_f1;
            r_f2    <= n_f2;
            r_blend <= ~i_cfg.overlay_mode;
        end
    end

    assign o_f1    = r_f1;
    assign o_f2    = r_f2;
    assign o_blend = r_blend;

endmodule

// ===== src/rab_color_lane.sv =====
// One color channel: premultiply (weighted blend mode only), weight, sum and divide by 65280.
module rab_color_lane (
    input  logic                       i_clk,
    input  rab_pkg::t_pipe_en          i_en,
    input  logic                       i_blend,
    input  logic [rab_pkg::CHAN_W-1:0] i_c1,
    input  logic [rab_pkg::CHAN_W-1:0] i_a1,
    input  logic [rab_pkg::CHAN_W-1:0] i_c2,
    input  logic [rab_pkg::CHAN_W-1:0] i_a2,
    input  logic [rab_pkg::FAC_W-1:0]  i_f1,
    input  logic [rab_pkg::FAC_W-1:0]  i_f2,
    output logic [rab_pkg::CHAN_W-1:0] o_c
);
    import rab_pkg::*;

    logic [MUL_W-1:0]  r_m1, r_m2;
    logic [SUM_W-1:0]  r_p1, r_p2;
    logic [SUM_W-1:0]  r_sum;
    logic [CHAN_W-1:0] r_c;
    logic [31:0]       p1_full, p2_full;

    assign p1_full = 32'(r_m1) * 32'(i_f1);
    assign p2_full = 32'(r_m2) * 32'(i_f2);

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_m1 <= i_blend ? MUL_W'(i_c1) * MUL_W'(i_a1) : MUL_W'(i_c1);
            r_m2 <= i_blend ? MUL_W'(i_c2) * MUL_W'(i_a2) : MUL_W'(i_c2);
        end
        if (i_en.s2) begin
            r_p1 <= p1_full[SUM_W-1:0];
            r_p2 <= p2_full[SUM_W-1:0];
        end
        if (i_en.s3) begin
            r_sum <= r_p1 + r_p2;
        end
        if (i_en.s4) begin
            r_c <= div255(r_sum[SUM_W-1:8]);
        end
    end

    assign o_c = r_c;

endmodule

// ===== src/rgba_alpha_blend_unit.sv =====
// Top level of the RGBA alpha blend unit: overlay or weighted blend of two pixels.
//
//  channel   | dir | handshake                    | payload
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | s_axis_tdata, 64 bits, two RGBA8 pixels
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | m_axis_tdata, 32 bits, one RGBA8 pixel
//  apb       | in  | psel/penable/pwrite/pready   | paddr 3 bits, pwdata/prdata 32 bits
//
//  Four register stages: factors, products, sum, divide by 255 into the output register.
//  One item per cycle while m_axis_tready is high; m_axis_tvalid is stage four's valid bit.
//  Each stage advances when it is empty or the stage after it advances; a stall at
//  m_axis_tready backs up stage by stage and s_axis_tready falls only when all are full.
//  Synchronous active-low reset clears valid bits and sets overlay_mode 0, blend_weight 128.
module rgba_alpha_blend_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // first_red, first_green, first_blue, first_alpha,
    // second_red, second_green, second_blue, second_alpha
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rab_pkg::*;

    t_cfg              cfg;
    t_pipe_en          en;
    logic [FAC_W-1:0]  f1, f2;
    logic              blend_s1;
    logic [CHAN_W-1:0] c1 [3];
    logic [CHAN_W-1:0] c2 [3];
    logic [CHAN_W-1:0] c_out [3];
    logic [CHAN_W-1:0] a1, a2;
    logic [CHAN_W-1:0] r_a1, r_a2;
    logic [CHAN_W-1:0] r_a_s2, r_a_s3, r_a_s4;
    logic [16:0]       a_sum;

    rab_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rab_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_en        (en)
    );

    assign a1 = s_axis_tdata[31:24];
    assign a2 = s_axis_tdata[63:56];

    rab_factor_stage u_factor (
        .i_clk          (i_clk),
        .i_en           (en.s1),
        .i_cfg          (cfg),
        .i_second_alpha (a2),
        .o_f1           (f1),
        .o_f2           (f2),
        .o_blend        (blend_s1)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        assign c1[g] = s_axis_tdata[8*g +: 8];
        assign c2[g] = s_axis_tdata[32 + 8*g +: 8];

        rab_color_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_blend (~cfg.overlay_mode),
            .i_c1    (c1[g]),
            .i_a1    (a1),
            .i_c2    (c2[g]),
            .i_a2    (a2),
            .i_f1    (f1),
            .i_f2    (f2),
            .o_c     (c_out[g])
        );
    end

    assign a_sum = 17'(r_a1) * 17'(f1[WGT_W-1:0]) + 17'(r_a2) * 17'(f2[WGT_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_a1 <= a1;
            r_a2 <= a2;
        end
        if (en.s2) begin
            r_a_s2 <= blend_s1 ? a_sum[15:8] : r_a1;
        end
        if (en.s3) begin
            r_a_s3 <= r_a_s2;
        end
        if (en.s4) begin
            r_a_s4 <= r_a_s3;
        end
    end

    assign m_axis_tdata = {r_a_s4, c_out[2], c_out[1], c_out[0]};

endmodule
